[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros clock on i_clk and are off while i_rst_n is low.

`define DMPC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`define DMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dmpc_pkg.sv]
package dmpc_pkg;

    localparam int unsigned KEY_W      = 64;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned AGE_W      = 8;
    localparam int unsigned PAY_PORT_W = 32;

    localparam int unsigned TABLE_ENTRIES_DEF = 65536;
    localparam int unsigned PAYLOAD_BITS_DEF  = 32;

    // Key reduction for table sizes that are not a power of two.
    localparam int unsigned RED_DIGIT_W = 4;
    localparam int unsigned RED_STEPS   = KEY_W / RED_DIGIT_W;

    localparam logic [KIND_W-1:0] KIND_EXACT       = 2'd0;
    localparam logic [AGE_W-1:0]  AGE_MARGIN_RESET = 8'd20;
    localparam logic [KEY_W-1:0]  EMPTY_KEY        = '0;

    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_LOOKUP,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic clear_we;
        logic load_item;
        logic red_step;
        logic rd_input;
        logic rd_slot;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_status;

endpackage

[design/dmpc_if.sv]
interface dmpc_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [dmpc_pkg::KEY_W-1:0]      key;
    logic [dmpc_pkg::KIND_W-1:0]     bound_kind;
    logic [dmpc_pkg::AGE_W-1:0]      entry_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0] payload;

    modport source (output valid, command, key, bound_kind, entry_age, payload,
                    input ready);
    modport sink (input valid, command, key, bound_kind, entry_age, payload,
                  output ready);
endinterface

interface dmpc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [dmpc_pkg::KIND_W-1:0]     found_kind;
    logic [dmpc_pkg::AGE_W-1:0]      found_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0] found_payload;
    logic                           written;

    modport source (output valid, hit, found_kind, found_age, found_payload, written,
                    input ready);
    modport sink (input valid, hit, found_kind, found_age, found_payload, written,
                  output ready);
endinterface

interface dmpc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [dmpc_pkg::AGE_W-1:0] age_margin;

    modport source (output valid, age_margin, input ready);
    modport sink (input valid, age_margin, output ready);
endinterface

[design/direct_mapped_position_cache.sv]
// Direct-mapped table of search results addressed by a 64-bit position key; the slot is the
// key modulo TABLE_ENTRIES and a stored key of zero marks an empty slot. After reset the block
// sweeps the whole table, one entry per cycle, before it takes its first item; age_margin
// writes are taken at any time. Each find or insert is one read and, for an insert that wins
// the replacement rule, one write of the single-port-read table memory: with a power-of-two
// table the memory read is registered, then the item is decided and written; otherwise the key
// is first reduced modulo the table size four bits per cycle, then the slot is read. The result
// sits in an output register, and the next item is accepted while it waits to be taken.
module direct_mapped_position_cache #(
    parameter int unsigned TABLE_ENTRIES = dmpc_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned PAYLOAD_BITS  = dmpc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmpc_req_if.sink    i_req,
    dmpc_rsp_if.source  o_rsp,
    dmpc_cfg_if.sink    i_cfg
);

    dmpc_pkg::t_dp_cmd    w_cmd;
    dmpc_pkg::t_dp_status w_status;
    logic                 w_req_ready;

    dmpc_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_req_ready;

    dmpc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_cfg    (i_cfg)
    );

endmodule

[design/dmpc_ram.sv]
module dmpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dmpc_ctrl.sv]
`include "assert_macros.svh"

module dmpc_ctrl #(
    parameter int unsigned TABLE_ENTRIES = dmpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  dmpc_pkg::t_dp_status i_status,
    output dmpc_pkg::t_dp_cmd    o_cmd
);

    localparam bit          POW2     = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int unsigned CNT_W    = $clog2(dmpc_pkg::RED_STEPS);
    localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(dmpc_pkg::RED_STEPS - 1);

    dmpc_pkg::t_state r_state;
    dmpc_pkg::t_state n_state;
    logic [CNT_W-1:0] r_red_cnt;
    logic [CNT_W-1:0] n_red_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmpc_pkg::ST_CLEAR;
            r_red_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_red_cnt <= n_red_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_red_cnt = r_red_cnt;
        unique case (r_state)
            dmpc_pkg::ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = dmpc_pkg::ST_IDLE;
                end
            end
            dmpc_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_red_cnt = '0;
                    if (POW2) begin
                        n_state = dmpc_pkg::ST_DECIDE;
                    end else begin
                        n_state = dmpc_pkg::ST_REDUCE;
                    end
                end
            end
            dmpc_pkg::ST_REDUCE: begin
                n_red_cnt = r_red_cnt + 1'b1;
                if (r_red_cnt == RED_LAST) begin
                    n_state = dmpc_pkg::ST_LOOKUP;
                end
            end
            dmpc_pkg::ST_LOOKUP: begin
                n_state = dmpc_pkg::ST_DECIDE;
            end
            dmpc_pkg::ST_DECIDE: begin
                if (i_status.out_free) begin
                    n_state = dmpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dmpc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            dmpc_pkg::ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
            end
            dmpc_pkg::ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.load_item = i_req_valid;
                // With a power-of-two table the slot is a slice of the key,
                // so the read goes out in the cycle the item is taken.
                o_cmd.rd_input  = i_req_valid && POW2;
            end
            dmpc_pkg::ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
            end
            dmpc_pkg::ST_LOOKUP: begin
                o_cmd.rd_slot = 1'b1;
            end
            dmpc_pkg::ST_DECIDE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `DMPC_ASSERT_NEXT(a_decide_waits, (r_state == dmpc_pkg::ST_DECIDE) && !i_status.out_free, r_state == dmpc_pkg::ST_DECIDE, "decision left while output register busy")
    `DMPC_ASSERT_NEXT(a_clear_once, r_state != dmpc_pkg::ST_CLEAR, r_state != dmpc_pkg::ST_CLEAR, "clearing pass restarted without reset")

endmodule

[design/dmpc_datapath.sv]
`include "assert_macros.svh"

module dmpc_datapath #(
    parameter int unsigned TABLE_ENTRIES = dmpc_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned PAYLOAD_BITS  = dmpc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmpc_pkg::t_dp_cmd     i_cmd,
    output dmpc_pkg::t_dp_status  o_status,
    dmpc_req_if.sink              i_req,
    dmpc_rsp_if.source            o_rsp,
    dmpc_cfg_if.sink              i_cfg
);

    localparam bit          POW2     = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int unsigned IDXP_W   = IDX_W + 1;
    localparam int unsigned PAY_KEEP = (PAYLOAD_BITS < dmpc_pkg::PAY_PORT_W) ?
                                       PAYLOAD_BITS : dmpc_pkg::PAY_PORT_W;
    localparam int unsigned INFO_W   = dmpc_pkg::KIND_W + dmpc_pkg::AGE_W + PAYLOAD_BITS;
    localparam int unsigned ENTRY_W  = dmpc_pkg::KEY_W + INFO_W;
    localparam logic [IDXP_W-1:0] MOD_N    = IDXP_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // Folds one key digit into the running remainder, one bit at a time.
    function automatic logic [IDX_W-1:0] f_mod_step(
        input logic [IDX_W-1:0]                 rem,
        input logic [dmpc_pkg::RED_DIGIT_W-1:0] digit
    );
        logic [IDXP_W-1:0] t;
        logic [IDX_W-1:0]  r;
        r = rem;
        for (int i = dmpc_pkg::RED_DIGIT_W - 1; i >= 0; i--) begin
            t = {r, digit[i]};
            if (t >= MOD_N) begin
                t = t - MOD_N;
            end
            r = t[IDX_W-1:0];
        end
        return r;
    endfunction

    // Item registers.
    logic                               r_command;
    logic [dmpc_pkg::KEY_W-1:0]         r_key;
    logic [dmpc_pkg::KIND_W-1:0]        r_kind;
    logic [dmpc_pkg::AGE_W-1:0]         r_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0]    r_pay;
    logic [IDX_W-1:0]                   r_slot;
    logic [dmpc_pkg::KEY_W-1:0]         r_red_key;

    // Control registers.
    logic [IDX_W-1:0]                   r_clr_addr;
    logic [dmpc_pkg::AGE_W-1:0]         r_margin;
    logic                               r_out_valid;

    // Result registers.
    logic                               r_hit;
    logic [dmpc_pkg::KIND_W-1:0]        r_found_kind;
    logic [dmpc_pkg::AGE_W-1:0]         r_found_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0]    r_found_payload;
    logic                               r_written;

    logic                               n_hit;
    logic [dmpc_pkg::KIND_W-1:0]        n_found_kind;
    logic [dmpc_pkg::AGE_W-1:0]         n_found_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0]    n_found_payload;
    logic                               n_written;

    logic [ENTRY_W-1:0]                 w_rd_entry;
    logic [dmpc_pkg::KEY_W-1:0]         w_rd_key;
    logic [dmpc_pkg::KIND_W-1:0]        w_rd_kind;
    logic [dmpc_pkg::AGE_W-1:0]         w_rd_age;
    logic [dmpc_pkg::PAY_PORT_W-1:0]    w_rd_pay;
    logic [PAYLOAD_BITS-1:0]            w_pay_store;
    logic [dmpc_pkg::AGE_W-1:0]         w_age_sum;
    logic                               w_hit;
    logic                               w_take;
    logic                               w_is_insert;
    logic                               w_we;
    logic [IDX_W-1:0]                   w_waddr;
    logic [ENTRY_W-1:0]                 w_wdata;
    logic                               w_re;
    logic [IDX_W-1:0]                   w_raddr;
    logic [dmpc_pkg::RED_DIGIT_W-1:0]   w_digit;

    assign w_digit = r_red_key[dmpc_pkg::KEY_W-1 -: dmpc_pkg::RED_DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_margin    <= dmpc_pkg::AGE_MARGIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_margin <= i_cfg.age_margin;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_command <= i_req.command;
            r_key     <= i_req.key;
            r_kind    <= i_req.bound_kind;
            r_age     <= i_req.entry_age;
            r_pay     <= i_req.payload;
            r_red_key <= i_req.key;
            r_slot    <= POW2 ? i_req.key[IDX_W-1:0] : '0;
        end else if (i_cmd.red_step) begin
            r_slot    <= f_mod_step(r_slot, w_digit);
            r_red_key <= r_red_key << dmpc_pkg::RED_DIGIT_W;
        end
        if (i_cmd.commit) begin
            r_hit           <= n_hit;
            r_found_kind    <= n_found_kind;
            r_found_age     <= n_found_age;
            r_found_payload <= n_found_payload;
            r_written       <= n_written;
        end
    end

    // Entry layout: key, kind, age, payload from high to low.
    assign w_rd_key  = w_rd_entry[ENTRY_W-1 -: dmpc_pkg::KEY_W];
    assign w_rd_kind = w_rd_entry[INFO_W-1 -: dmpc_pkg::KIND_W];
    assign w_rd_age  = w_rd_entry[PAYLOAD_BITS +: dmpc_pkg::AGE_W];

    always_comb begin
        w_rd_pay                 = '0;
        w_rd_pay[PAY_KEEP-1:0]   = w_rd_entry[PAY_KEEP-1:0];
        w_pay_store              = '0;
        w_pay_store[PAY_KEEP-1:0] = r_pay[PAY_KEEP-1:0];
    end

    // The age sum wraps at eight bits.
    assign w_age_sum   = w_rd_age + r_margin;
    assign w_hit       = (w_rd_key == r_key);
    assign w_is_insert = (r_command == dmpc_pkg::CMD_INSERT);
    assign w_take      = (w_rd_key == dmpc_pkg::EMPTY_KEY)
                      || (w_rd_kind != dmpc_pkg::KIND_EXACT)
                      || (r_kind == dmpc_pkg::KIND_EXACT)
                      || (w_age_sum < r_age);

    always_comb begin
        n_hit           = 1'b0;
        n_found_kind    = '0;
        n_found_age     = '0;
        n_found_payload = '0;
        n_written       = 1'b0;
        case (r_command)
            dmpc_pkg::CMD_FIND: begin
                n_hit = w_hit;
                if (w_hit) begin
                    n_found_kind    = w_rd_kind;
                    n_found_age     = w_rd_age;
                    n_found_payload = w_rd_pay;
                end
            end
            dmpc_pkg::CMD_INSERT: begin
                n_written = w_take;
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    assign w_we    = i_cmd.clear_we || (i_cmd.commit && w_is_insert && w_take);
    assign w_waddr = i_cmd.clear_we ? r_clr_addr : r_slot;
    assign w_wdata = i_cmd.clear_we ? '0 : {r_key, r_kind, r_age, w_pay_store};
    assign w_re    = i_cmd.rd_input || i_cmd.rd_slot;
    assign w_raddr = i_cmd.rd_input ? i_req.key[IDX_W-1:0] : r_slot;

    dmpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_entry)
    );

    assign o_status.clear_last = (r_clr_addr == IDX_LAST);
    assign o_status.out_free   = !r_out_valid || o_rsp.ready;

    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.found_kind    = r_found_kind;
    assign o_rsp.found_age     = r_found_age;
    assign o_rsp.found_payload = r_found_payload;
    assign o_rsp.written       = r_written;

    `DMPC_ASSERT(a_commit_room, !i_cmd.commit || !r_out_valid || o_rsp.ready, "result loaded over one not yet taken")
    `DMPC_ASSERT(a_hit_xor_written, !(r_out_valid && r_hit && r_written), "result reports both a hit and a write")

endmodule

[test/dmpc_checker.sv]
module dmpc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dmpc_req_if  i_req,
    dmpc_rsp_if  i_rsp,
    dmpc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dmpc_pkg::*;

    localparam logic [PAY_PORT_W-1:0] PAY_KEEP = PAY_PORT_W'((64'd1 << PAYLOAD_BITS_DEF) - 1);

    typedef struct packed {
        bit [KIND_W-1:0]     kind;
        bit [AGE_W-1:0]      age;
        bit [PAY_PORT_W-1:0] payload;
    } t_slot_info;

    typedef struct packed {
        logic                  hit;
        logic [KIND_W-1:0]     kind;
        logic [AGE_W-1:0]      age;
        logic [PAY_PORT_W-1:0] payload;
        logic                  written;
    } t_answer;

    // Shadow copy of the table; bit arrays start at zero, as the cleared store does.
    bit [KEY_W-1:0]   stored_key [TABLE_ENTRIES_DEF];
    t_slot_info       stored_info [TABLE_ENTRIES_DEF];
    logic [AGE_W-1:0] cur_margin = AGE_MARGIN_RESET;
    t_answer          answers_due [$];

    function automatic t_answer run_probe(logic cmd, logic [KEY_W-1:0] key,
                                          logic [KIND_W-1:0] kind, logic [AGE_W-1:0] age,
                                          logic [PAY_PORT_W-1:0] pay);
        int unsigned      idx;
        t_slot_info       old;
        logic [AGE_W-1:0] aged;
        t_answer          ans;
        idx  = int'(key % TABLE_ENTRIES_DEF);
        old  = stored_info[idx];
        ans  = '0;
        if (cmd == CMD_FIND) begin
            if (stored_key[idx] == key) begin
                ans.hit     = 1'b1;
                ans.kind    = old.kind;
                ans.age     = old.age;
                ans.payload = old.payload;
            end
        end else begin
            // The sum is eight bits wide, so it wraps the way the block's age compare does.
            aged = old.age + cur_margin;
            if (stored_key[idx] == EMPTY_KEY || old.kind != KIND_EXACT ||
                kind == KIND_EXACT || aged < age) begin
                stored_key[idx]          = key;
                stored_info[idx].kind    = kind;
                stored_info[idx].age     = age;
                stored_info[idx].payload = pay & PAY_KEEP;
                ans.written              = 1'b1;
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: result mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_cfg.valid && i_cfg.ready) begin
                cur_margin = i_cfg.age_margin;
            end
            if (i_req.valid && i_req.ready) begin
                answers_due.push_back(run_probe(i_req.command, i_req.key, i_req.bound_kind,
                                                i_req.entry_age, i_req.payload));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("item arrived with nothing outstanding");
                end else begin
                    want = answers_due.pop_front();
                    check_field("hit", i_rsp.hit, want.hit);
                    check_field("found_kind", i_rsp.found_kind, want.kind);
                    check_field("found_age", i_rsp.found_age, want.age);
                    check_field("found_payload", i_rsp.found_payload, want.payload);
                    check_field("written", i_rsp.written, want.written);
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dmpc_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_ITEMS = 110;

    localparam logic [KIND_W-1:0] KIND_LOWER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPPER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_ONES    = '1;
    localparam logic [KEY_W-1:0] KEY_TOP_A   = 64'h0000_0001_0000_FFFF;
    localparam logic [KEY_W-1:0] KEY_TOP_B   = 64'h0000_0002_0000_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO_A  = 64'h0000_0000_0001_0000;
    localparam logic [KEY_W-1:0] KEY_ZERO_B  = 64'h0000_0000_0002_0000;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_W-1:0]      key;
        logic [KIND_W-1:0]     kind;
        logic [AGE_W-1:0]      age;
        logic [PAY_PORT_W-1:0] pay;
    } t_probe;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   stall_left = 0;
    int   stall_cycle = 0;

    dmpc_req_if req_ch ();
    dmpc_rsp_if rsp_ch ();
    dmpc_cfg_if cfg_ch ();

    direct_mapped_position_cache u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    dmpc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // The receiver cycles through stall modes, one of them never stalling.
    always @(negedge clk) begin
        stall_cycle++;
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready <= 1'b1;
            case ((stall_cycle / 256) % 4)
                1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 2);
                2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 6);
                3: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
                default: stall_left = 0;
            endcase
        end
    end

    function automatic t_probe mk(logic cmd, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                                  logic [AGE_W-1:0] age, logic [PAY_PORT_W-1:0] pay);
        t_probe p;
        p.cmd  = cmd;
        p.key  = key;
        p.kind = kind;
        p.age  = age;
        p.pay  = pay;
        return p;
    endfunction

    // Keys crowd onto a few slots at both ends of the table so that finds hit and inserts
    // contend; the upper bits come from a small pool with the odd random value.
    function automatic t_probe random_probe();
        logic [15:0]       slot;
        logic [47:0]       upper;
        logic [KIND_W-1:0] kind;
        int                pick;
        pick = $urandom_range(0, 15);
        if (pick < 10) begin
            slot = {12'h000, 4'($urandom)};
        end else if (pick < 14) begin
            slot = {12'hFFF, 4'($urandom)};
        end else begin
            slot = 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: upper = '0;
            1: upper = 48'd1;
            2: upper = '1;
            default: upper = {16'($urandom), 32'($urandom)};
        endcase
        kind = ($urandom_range(0, 1) == 0) ? KIND_EXACT : 2'($urandom_range(1, 3));
        return mk(($urandom_range(0, 1) == 0) ? CMD_FIND : CMD_INSERT, {upper, slot}, kind,
                  8'($urandom), 32'($urandom));
    endfunction

    task automatic send_probe(t_probe p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.command    <= p.cmd;
        req_ch.key        <= p.key;
        req_ch.bound_kind <= p.kind;
        req_ch.entry_age  <= p.age;
        req_ch.payload    <= p.pay;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0 && spins < DRAIN_LIMIT) begin
            @(negedge clk);
            spins++;
        end
    endtask

    task automatic write_margin(logic [AGE_W-1:0] margin);
        repeat (2) @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.age_margin <= margin;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [AGE_W-1:0] margins [5];
        margins = '{8'd0, 8'd255, 8'($urandom), 8'd1, 8'($urandom)};
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_FIND;
        req_ch.key        = '0;
        req_ch.bound_kind = KIND_EXACT;
        req_ch.entry_age  = '0;
        req_ch.payload    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.age_margin = AGE_MARGIN_RESET;
        rsp_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset margin of 20.
        send_probe(mk(CMD_FIND, '0, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_FIND, KEY_ONES, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, KEY_ONES, KIND_EXACT, 8'd255, '1));
        send_probe(mk(CMD_FIND, KEY_ONES, KIND_EXACT, '0, '0));
        // Stored age 255 plus the margin wraps to 19: age 0 is dropped, age 20 replaces.
        send_probe(mk(CMD_INSERT, KEY_TOP_A, KIND_LOWER, 8'd0, '0));
        send_probe(mk(CMD_INSERT, KEY_TOP_A, KIND_UPPER, 8'd20, 32'h0000_FFFF));
        send_probe(mk(CMD_FIND, KEY_ONES, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, KEY_ONES, KIND_EXACT, 8'd5, 32'h8000_0001));
        send_probe(mk(CMD_INSERT, KEY_TOP_B, KIND_EXACT, 8'd0, 32'hDEAD_BEEF));
        send_probe(mk(CMD_INSERT, KEY_TOP_A, KIND_LOWER, 8'd20, 32'd1));
        send_probe(mk(CMD_INSERT, KEY_TOP_A, KIND_LOWER, 8'd21, 32'd2));
        send_probe(mk(CMD_FIND, KEY_TOP_A, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, 64'd5, KIND_UNUSED, 8'd7, 32'hA5A5_A5A5));
        send_probe(mk(CMD_FIND, 64'd5, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, 64'd5, KIND_EXACT, 8'd8, 32'h5A5A_5A5A));
        // Key zero: it is stored, yet its slot still counts as empty afterwards.
        send_probe(mk(CMD_INSERT, '0, KIND_EXACT, 8'd9, 32'h0000_1234));
        send_probe(mk(CMD_FIND, '0, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, KEY_ZERO_A, KIND_LOWER, 8'd3, '0));
        send_probe(mk(CMD_FIND, '0, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_INSERT, KEY_ZERO_B, KIND_EXACT, 8'd100, 32'd7));
        send_probe(mk(CMD_INSERT, '0, KIND_LOWER, 8'd50, 32'd8));
        send_probe(mk(CMD_INSERT, '0, KIND_EXACT, 8'd51, 32'd9));
        send_probe(mk(CMD_FIND, KEY_ZERO_B, KIND_EXACT, '0, '0));
        send_probe(mk(CMD_FIND, '0, KIND_EXACT, '0, '0));

        foreach (margins[m]) begin
            wait_drained();
            write_margin(margins[m]);
            repeat (PHASE_ITEMS) send_probe(random_probe());
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
